// ----- rtl/sawv_pkg.sv -----
// ----------------------------------------------------------------------------
// sawv_pkg: shared constants for the sawtooth voice
// Phase resolution, arithmetic widths, action and register codes.
// ----------------------------------------------------------------------------
package sawv_pkg;

  // phase accumulator resolution, one cycle = 2^PHASE_BITS (12..32)
  localparam int PHASE_BITS = 24;

  // field widths
  localparam int ACTION_W = 2;
  localparam int STEP_IN_W = 23;
  localparam int STEP_IN_FRAC = 24;
  localparam int VEL_W = 7;
  localparam int SAMPLE_W = 16;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;

  // level gain is round(velocity * 9830 / 127), 9830 = 0.15 in Q0.16
  localparam int LEVEL_MAX = 9830;
  localparam int LEVEL_DIVISOR = 127;
  localparam int LEVEL_ROUND = 63;
  localparam int LEVEL_W = 14;

  // release gain Q1.16
  localparam int GAIN_W = 17;
  localparam int GAIN_FRAC = 16;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

  // serial multiplier: multiplicand holds |phase| * level, multiplier holds a gain
  localparam int MUL_A_W = PHASE_BITS + LEVEL_W;
  localparam int MUL_B_W = GAIN_W;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  // product scaling down to Q1.15
  localparam int OUT_SHIFT = PHASE_BITS + GAIN_W;
  localparam int RND_W = MUL_P_W - OUT_SHIFT + 1;

  // serial divider for the level gain
  localparam int DIV_W = 21;
  localparam int REM_W = 7;

  // step counter covers the longer of the two serial loops
  localparam int CNT_W = 5;

  // configuration defaults
  localparam logic [CFG_W-1:0] DECAY_RESET = 16'd64881;
  localparam logic [CFG_W-1:0] THRESH_RESET = 16'd328;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_TICK = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_NOTE_ON = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_NOTE_OFF = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 1'd1;

endpackage

// ----- rtl/sawtooth_voice_with_release.sv -----
// ----------------------------------------------------------------------------
// sawtooth_voice_with_release: one sawtooth synthesizer voice with release
// Phase accumulator ramp scaled by velocity level and a decaying release gain.
// ----------------------------------------------------------------------------
// One item is handled at a time and every item gives one result. Note-off and
// release requests and ticks of a silent voice go straight to the result
// stage. A note-on runs the bit-serial divide by 127 that forms the level
// gain (21 steps). A tick of a sounding voice uses one shared bit-serial
// multiplier: it forms |phase| * level, then times the gain, and while the
// release tail runs it then forms the decayed release gain, 17 steps each.
// The output register lets the next item be taken while a result waits.
// After reset decay_factor is 64881 (0.99) and stop_threshold is 328
// (0.005), both Q0.16, and the voice is silent.

module sawtooth_voice_with_release (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration writes
  input  logic                                  cfg_en,
  input  logic [sawv_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sawv_pkg::CFG_W-1:0]            cfg_data,
  // input items
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [sawv_pkg::ACTION_W-1:0]         action,
  input  logic [sawv_pkg::STEP_IN_W-1:0]        phase_step,
  input  logic [sawv_pkg::VEL_W-1:0]            velocity,
  // result items
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [sawv_pkg::SAMPLE_W-1:0]  sample,
  output logic                                  voice_active
);

  localparam int PB = sawv_pkg::PHASE_BITS;
  localparam int AW = sawv_pkg::MUL_A_W;
  localparam int BW = sawv_pkg::MUL_B_W;
  localparam int PW = sawv_pkg::MUL_P_W;
  localparam int SH = sawv_pkg::OUT_SHIFT;
  localparam int RW = sawv_pkg::RND_W;
  localparam int GW = sawv_pkg::GAIN_W;
  localparam int GF = sawv_pkg::GAIN_FRAC;
  localparam int DW = sawv_pkg::DIV_W;
  localparam int MW = sawv_pkg::REM_W;
  localparam int SW = sawv_pkg::SAMPLE_W;
  localparam int CW = sawv_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MUL_LEVEL,
    S_MUL_GAIN,
    S_DECAY,
    S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [sawv_pkg::CFG_W-1:0] decay_factor;
  logic [sawv_pkg::CFG_W-1:0] stop_threshold;

  // voice state
  logic [PB-1:0]                 phase;
  logic [PB-1:0]                 step_store;
  logic [sawv_pkg::LEVEL_W-1:0]  level_gain;
  logic [GW-1:0]                 release_gain;
  logic                          active_flag;

  // work registers
  logic [AW-1:0]  mul_a;
  logic [PW-1:0]  mul_p;
  logic [CW-1:0]  cnt;
  logic [MW-1:0]  div_rem;
  logic [DW-1:0]  div_num;
  logic           neg;
  logic [SW-1:0]  res_sample;

  // input decode
  logic [PB+sawv_pkg::STEP_IN_FRAC-1:0] step_wide;
  logic [PB-1:0]                        step_scaled;
  logic [PB-1:0]                        mag;
  logic [DW-1:0]                        vel_scaled;

  // serial step results
  logic [AW:0]    mul_sum;
  logic [PW-1:0]  mul_p_next;
  logic           mul_last;
  logic [MW:0]    div_shift;
  logic           div_ge;
  logic [MW-1:0]  div_rem_next;
  logic [DW-1:0]  div_num_next;
  logic           div_last;
  logic [RW-1:0]  rnd;
  logic [SW-1:0]  rnd_ext;
  logic [GW-1:0]  gain_sel;
  logic [GW-1:0]  decayed;
  logic           out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Q0.24 step to phase resolution: s * 2^PB / 2^24, truncated
  assign step_wide   = {1'b0, phase_step, PB'(0)};
  assign step_scaled = step_wide[PB+sawv_pkg::STEP_IN_FRAC-1:sawv_pkg::STEP_IN_FRAC];

  // ramp magnitude, the most negative phase gives 2^(PB-1)
  assign mag = phase[PB-1] ? (~phase + PB'(1)) : phase;

  // velocity * 9830 + 63, dividend of the level divide
  assign vel_scaled = DW'(velocity) * DW'(sawv_pkg::LEVEL_MAX) + DW'(sawv_pkg::LEVEL_ROUND);

  // shift-add multiplier step, one multiplier bit per cycle
  assign mul_sum    = {1'b0, mul_p[PW-1:BW]} + (mul_p[0] ? {1'b0, mul_a} : (AW+1)'(0));
  assign mul_p_next = {mul_sum, mul_p[BW-1:1]};
  assign mul_last   = (cnt == CW'(BW - 1));

  // restoring divide step by 127, one quotient bit per cycle
  assign div_shift    = {div_rem, div_num[DW-1]};
  assign div_ge       = (div_shift >= (MW+1)'(sawv_pkg::LEVEL_DIVISOR));
  assign div_rem_next = div_ge ? MW'(div_shift - (MW+1)'(sawv_pkg::LEVEL_DIVISOR))
                               : div_shift[MW-1:0];
  assign div_num_next = {div_num[DW-2:0], div_ge};
  assign div_last     = (cnt == CW'(DW - 1));

  // scale to Q1.15, round half away from zero on the magnitude; the product
  // bound keeps the magnitude well inside 15 bits, so no clipping is needed
  assign rnd     = {1'b0, mul_p_next[PW-1:SH]} + RW'(mul_p_next[SH-1]);
  assign rnd_ext = SW'(rnd);

  // sustain gain is unity, release uses the running tail
  assign gain_sel = (release_gain != '0) ? release_gain : sawv_pkg::GAIN_ONE;

  // floor(release_gain * decay_factor / 2^16)
  assign decayed = mul_p_next[GF+GW-1:GF];

  // sequencer, voice state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      decay_factor   <= sawv_pkg::DECAY_RESET;
      stop_threshold <= sawv_pkg::THRESH_RESET;
      phase          <= '0;
      step_store     <= '0;
      level_gain     <= '0;
      release_gain   <= '0;
      active_flag    <= 1'b0;
      out_valid      <= 1'b0;
      cnt            <= '0;
    end else begin
      // configuration writes
      if (cfg_en) begin
        unique case (cfg_index)
          sawv_pkg::REG_DECAY:  decay_factor   <= cfg_data;
          sawv_pkg::REG_THRESH: stop_threshold <= cfg_data;
          default: ;
        endcase
      end

      // result handoff, unless the next result is loaded in its place
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_sample <= '0;
            cnt        <= '0;
            unique case (action)
              sawv_pkg::ACT_NOTE_ON: begin
                phase        <= '0;
                release_gain <= '0;
                step_store   <= step_scaled;
                active_flag  <= (step_scaled != '0);
                div_rem      <= '0;
                div_num      <= vel_scaled;
                state        <= S_DIV;
              end
              sawv_pkg::ACT_RELEASE: begin
                if (active_flag && release_gain == '0) begin
                  release_gain <= sawv_pkg::GAIN_ONE;
                end
                state <= S_DONE;
              end
              sawv_pkg::ACT_NOTE_OFF: begin
                active_flag  <= 1'b0;
                step_store   <= '0;
                release_gain <= '0;
                state        <= S_DONE;
              end
              default: begin
                if (active_flag) begin
                  neg   <= phase[PB-1];
                  mul_a <= AW'(mag);
                  mul_p <= PW'(level_gain);
                  phase <= phase + step_store;
                  state <= S_MUL_LEVEL;
                end else begin
                  state <= S_DONE;
                end
              end
            endcase
          end
        end

        S_DIV: begin
          div_rem <= div_rem_next;
          div_num <= div_num_next;
          cnt     <= cnt + CW'(1);
          if (div_last) begin
            level_gain <= div_num_next[sawv_pkg::LEVEL_W-1:0];
            state      <= S_DONE;
          end
        end

        S_MUL_LEVEL: begin
          if (mul_last) begin
            mul_a <= mul_p_next[AW-1:0];
            mul_p <= PW'(gain_sel);
            cnt   <= '0;
            state <= S_MUL_GAIN;
          end else begin
            mul_p <= mul_p_next;
            cnt   <= cnt + CW'(1);
          end
        end

        S_MUL_GAIN: begin
          if (mul_last) begin
            res_sample <= neg ? (~rnd_ext + SW'(1)) : rnd_ext;
            cnt        <= '0;
            if (release_gain != '0) begin
              mul_a <= AW'(release_gain);
              mul_p <= PW'(decay_factor);
              state <= S_DECAY;
            end else begin
              state <= S_DONE;
            end
          end else begin
            mul_p <= mul_p_next;
            cnt   <= cnt + CW'(1);
          end
        end

        S_DECAY: begin
          mul_p <= mul_p_next;
          cnt   <= cnt + CW'(1);
          if (mul_last) begin
            if (decayed <= GW'(stop_threshold)) begin
              active_flag  <= 1'b0;
              step_store   <= '0;
              release_gain <= '0;
            end else begin
              release_gain <= decayed;
            end
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            sample       <= res_sample;
            voice_active <= active_flag;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // a silent voice never carries a release tail
  a_silent_no_tail: assert property (@(posedge clk) disable iff (rst)
    !active_flag |-> release_gain == '0)
    else $error("release gain held by a silent voice");

  // a sounding voice always has a nonzero step
  a_active_step: assert property (@(posedge clk) disable iff (rst)
    active_flag |-> step_store != '0)
    else $error("sounding voice with zero phase step");

  // the sequencer is busy in the cycle after every transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // a result is only loaded into a free output register
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !out_free |=> state == S_DONE)
    else $error("result loaded over a pending output");

endmodule
